### hw/rtl/b2s_pkg.sv
// shared types, constants and helper functions for the blake2s hash engine
package b2s_pkg;

  localparam int unsigned BlockBytes     = 64;
  localparam int unsigned MaxDigestBytes = 32;
  localparam int unsigned CntW           = 64;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  valid_bytes;
    logic        end_of_digest;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_LOAD,
    ST_ROUND,
    ST_FINISH,
    ST_EMIT
  } state_e;

  typedef enum logic [7:0] {
    REG_DIGEST_SIZE = 8'd0,
    REG_KEY_LENGTH  = 8'd1
  } reg_idx_e;

  localparam logic [31:0] ParamBase = 32'h0101_0000;

  localparam logic [31:0] IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  // digest size with out-of-range values folded into 1..32
  function automatic logic [5:0] eff_digest(input logic [5:0] ds);
    logic [5:0] r;
    if (ds == 6'd0) begin
      r = 6'd1;
    end else if (ds > 6'(MaxDigestBytes)) begin
      r = 6'(MaxDigestBytes);
    end else begin
      r = ds;
    end
    return r;
  endfunction

  function automatic logic [31:0] param_word(input logic [5:0] ds, input logic [5:0] kl);
    logic [5:0] k;
    k = (kl > 6'd32) ? 6'd32 : kl;
    return ParamBase | {18'd0, k, 8'd0} | {26'd0, eff_digest(ds)};
  endfunction

endpackage

### hw/rtl/b2s_g_half.sv
// one half of the blake2s g function, shared over all steps of a compression
module b2s_g_half (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  input  logic [31:0] m_i,
  input  logic        second_i,
  output logic [31:0] a_o,
  output logic [31:0] b_o,
  output logic [31:0] c_o,
  output logic [31:0] d_o
);

  logic [31:0] dx, bx;

  always_comb begin
    a_o = a_i + b_i + m_i;
    dx  = d_i ^ a_o;
    // rotate right by 16/12 in the first half, 8/7 in the second
    d_o = second_i ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
    c_o = c_i + d_o;
    bx  = b_i ^ c_o;
    b_o = second_i ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
  end

endmodule

### hw/rtl/blake2s_hash_engine_unit.sv
// blake2s hash engine top level: byte packer, block buffer, compression sequencer
// operation: each accepted item is absorbed byte by byte; a full block is compressed only
//   once more bytes arrive (full check, load, half-g rounds, chain update); a final
//   item adds a pad step, a final compression and then the digest words in turn
// input: a new item is taken only in idle, once the last one is absorbed and any compression
//   or digest output it started is done; compression runs on the shared half-g unit
// reset: async active low; chain value is iv xor parameter word, counters cleared
module blake2s_hash_engine_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  b2s_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b2s_pkg::out_item_t  out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  b2s_pkg::state_e st_q, st_d;

  // configuration
  logic [5:0] ds_q, kl_q;

  // held input item, count already clamped to four
  logic [31:0] data_q;
  logic [2:0]  cnt_in_q;
  logic        last_q;
  logic [2:0]  bidx_q;

  // message state
  logic [6:0]  buf_q;
  logic [63:0] cnt_q;
  logic [31:0] h_q [8];
  logic [31:0] m_q [16];
  logic        final_q;

  // working vector kept as four rows; the g unit always works on column zero
  logic [31:0] v_q [4][4];
  logic [3:0]  round_q;
  logic [2:0]  gstep_q;
  logic        phase_q;
  logic [2:0]  ow_q;

  logic [31:0] ga, gb, gc, gd, gm;
  logic [5:0]  ds_eff;
  logic [3:0]  nwords;
  logic [5:0]  left;
  logic [2:0]  vb;
  logic        cfg_we;
  logic [5:0]  ds_new, kl_new;
  logic        absorb_more, blk_full;
  logic        last_g;
  logic [1:0]  rot [4];

  b2s_g_half u_g (
    .a_i      (v_q[0][0]),
    .b_i      (v_q[1][0]),
    .c_i      (v_q[2][0]),
    .d_i      (v_q[3][0]),
    .m_i      (gm),
    .second_i (phase_q),
    .a_o      (ga),
    .b_o      (gb),
    .c_o      (gc),
    .d_o      (gd)
  );

  assign gm = m_q[b2s_pkg::SIGMA[round_q][{gstep_q, phase_q}]];

  assign absorb_more = bidx_q < cnt_in_q;
  assign blk_full    = buf_q == 7'(b2s_pkg::BlockBytes);
  assign last_g      = (gstep_q == 3'd7) && phase_q;

  // row rotation after a full g: columns, then swing rows into diagonals and back
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rot[k] = 2'd1;
      if (gstep_q == 3'd3) begin
        rot[k] = 2'(k + 1);
      end else if (gstep_q == 3'd7) begin
        rot[k] = 2'(1 - k);
      end
    end
  end

  // digest word shaping
  assign ds_eff = b2s_pkg::eff_digest(ds_q);
  assign nwords = 4'((7'(ds_eff) + 7'd3) >> 2);
  assign left   = ds_eff - {1'b0, ow_q, 2'b00};
  assign vb     = (left > 6'd4) ? 3'd4 : left[2:0];

  always_comb begin
    out_item_o.valid_bytes   = vb;
    out_item_o.end_of_digest = ({1'b0, ow_q} + 4'd1) == nwords;
    for (int b = 0; b < 4; b++) begin
      out_item_o.digest_word[8*b +: 8] = (3'(b) < vb) ? h_q[ow_q][8*b +: 8] : 8'h00;
    end
  end

  // configuration decode
  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i &&
                  ((cfg_index_i == b2s_pkg::REG_DIGEST_SIZE) ||
                   (cfg_index_i == b2s_pkg::REG_KEY_LENGTH));
  assign ds_new = (cfg_index_i == b2s_pkg::REG_DIGEST_SIZE) ? cfg_data_i[5:0] : ds_q;
  assign kl_new = (cfg_index_i == b2s_pkg::REG_KEY_LENGTH)  ? cfg_data_i[5:0] : kl_q;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      b2s_pkg::ST_IDLE: begin
        if (in_valid_i) st_d = b2s_pkg::ST_ABSORB;
      end
      b2s_pkg::ST_ABSORB: begin
        if (absorb_more) begin
          if (blk_full) st_d = b2s_pkg::ST_LOAD;
        end else if (last_q) begin
          st_d = b2s_pkg::ST_LOAD;
        end else begin
          st_d = b2s_pkg::ST_IDLE;
        end
      end
      b2s_pkg::ST_LOAD:  st_d = b2s_pkg::ST_ROUND;
      b2s_pkg::ST_ROUND: begin
        if (last_g && round_q == 4'd9) st_d = b2s_pkg::ST_FINISH;
      end
      b2s_pkg::ST_FINISH: st_d = final_q ? b2s_pkg::ST_EMIT : b2s_pkg::ST_ABSORB;
      b2s_pkg::ST_EMIT: begin
        if (out_ready_i && out_item_o.end_of_digest) st_d = b2s_pkg::ST_IDLE;
      end
      default: st_d = b2s_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o  = st_q == b2s_pkg::ST_IDLE;
    out_valid_o = st_q == b2s_pkg::ST_EMIT;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= b2s_pkg::ST_IDLE;
      ds_q    <= 6'd32;
      kl_q    <= 6'd0;
      buf_q   <= '0;
      cnt_q   <= '0;
      final_q <= 1'b0;
      round_q <= '0;
      gstep_q <= '0;
      phase_q <= 1'b0;
      ow_q    <= '0;
      bidx_q  <= '0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= (i == 0) ? (b2s_pkg::IV[0] ^ b2s_pkg::param_word(6'd32, 6'd0))
                           : b2s_pkg::IV[i];
      end
    end else begin
      st_q <= st_d;
      if (cfg_we) begin
        ds_q <= ds_new;
        kl_q <= kl_new;
        // still at message start: reload chain with the new parameter word
        if (buf_q == 7'd0 && cnt_q == 64'd0) begin
          h_q[0] <= b2s_pkg::IV[0] ^ b2s_pkg::param_word(ds_new, kl_new);
        end
      end
      unique case (st_q)
        b2s_pkg::ST_IDLE: begin
          bidx_q <= '0;
        end
        b2s_pkg::ST_ABSORB: begin
          if (absorb_more) begin
            if (blk_full) begin
              cnt_q   <= cnt_q + 64'(b2s_pkg::BlockBytes);
              buf_q   <= '0;
              final_q <= 1'b0;
            end else begin
              buf_q  <= buf_q + 7'd1;
              bidx_q <= bidx_q + 3'd1;
            end
          end else if (last_q) begin
            cnt_q   <= cnt_q + 64'(buf_q);
            final_q <= 1'b1;
          end
        end
        b2s_pkg::ST_LOAD: begin
          round_q <= '0;
          gstep_q <= '0;
          phase_q <= 1'b0;
        end
        b2s_pkg::ST_ROUND: begin
          phase_q <= ~phase_q;
          if (phase_q) begin
            gstep_q <= gstep_q + 3'd1;
            if (gstep_q == 3'd7) round_q <= round_q + 4'd1;
          end
        end
        b2s_pkg::ST_FINISH: begin
          for (int i = 0; i < 8; i++) begin
            h_q[i] <= h_q[i] ^ v_q[i/4][i%4] ^ v_q[2 + i/4][i%4];
          end
          ow_q <= '0;
        end
        b2s_pkg::ST_EMIT: begin
          if (out_ready_i) begin
            ow_q <= ow_q + 3'd1;
            if (out_item_o.end_of_digest) begin
              // start the next message
              buf_q <= '0;
              cnt_q <= '0;
              for (int i = 0; i < 8; i++) begin
                h_q[i] <= (i == 0) ? (b2s_pkg::IV[0] ^ b2s_pkg::param_word(ds_q, kl_q))
                                   : b2s_pkg::IV[i];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers: held item, block buffer, working vector
  always_ff @(posedge clk_i) begin
    if (st_q == b2s_pkg::ST_IDLE && in_valid_i) begin
      data_q   <= in_item_i.data_word;
      cnt_in_q <= (in_item_i.byte_count > 3'd4) ? 3'd4 : in_item_i.byte_count;
      last_q   <= in_item_i.last_word;
    end
    if (st_q == b2s_pkg::ST_ABSORB) begin
      if (absorb_more) begin
        if (!blk_full) begin
          m_q[buf_q[5:2]][8*buf_q[1:0] +: 8] <= data_q[8*bidx_q[1:0] +: 8];
        end
      end else if (last_q) begin
        // zero pad everything past the buffered bytes
        for (int i = 0; i < 16; i++) begin
          for (int b = 0; b < 4; b++) begin
            if (7'(4*i + b) >= buf_q) m_q[i][8*b +: 8] <= 8'h00;
          end
        end
      end
    end
    if (st_q == b2s_pkg::ST_LOAD) begin
      for (int k = 0; k < 4; k++) begin
        v_q[0][k] <= h_q[k];
        v_q[1][k] <= h_q[4 + k];
        v_q[2][k] <= b2s_pkg::IV[k];
      end
      v_q[3][0] <= b2s_pkg::IV[4] ^ cnt_q[31:0];
      v_q[3][1] <= b2s_pkg::IV[5] ^ cnt_q[63:32];
      v_q[3][2] <= final_q ? ~b2s_pkg::IV[6] : b2s_pkg::IV[6];
      v_q[3][3] <= b2s_pkg::IV[7];
    end
    if (st_q == b2s_pkg::ST_ROUND) begin
      if (!phase_q) begin
        v_q[0][0] <= ga;
        v_q[1][0] <= gb;
        v_q[2][0] <= gc;
        v_q[3][0] <= gd;
      end else begin
        for (int k = 0; k < 4; k++) begin
          for (int j = 0; j < 4; j++) begin
            if (2'(j) + rot[k] == 2'd0) begin
              v_q[k][j] <= (k == 0) ? ga : (k == 1) ? gb : (k == 2) ? gc : gd;
            end else begin
              v_q[k][j] <= v_q[k][2'(j) + rot[k]];
            end
          end
        end
      end
    end
  end

endmodule

### hw/rtl/b2s_checker.sv
// port checker for the blake2s hash engine, bound to the top level
module b2s_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input b2s_pkg::out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("digest item dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after taking an item");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while digest is pending");

  a_vb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.valid_bytes != 3'd0 && out_item_o.valid_bytes <= 3'd4)
    else $error("digest valid byte count out of range");

endmodule

bind blake2s_hash_engine_unit b2s_checker u_b2s_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

### dv/testbench.sv
// self-checking testbench for the blake2s hash engine: directed and random message streams vs local digest model
module testbench;

  localparam int unsigned LimitCycles = 600000;
  localparam int unsigned SettleCycles = 400;
  localparam int unsigned HoldCycles = 700;
  localparam logic [7:0] RegUnmapped = 8'd2;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  b2s_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  b2s_pkg::out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  blake2s_hash_engine_unit dut (.*);

  always #10 clk_i = ~clk_i;

  // stimulus and expectation stores
  b2s_pkg::in_item_t word_q[$];
  b2s_pkg::out_item_t digest_q[$];
  int send_idle = 31;
  int recv_idle = 69;
  bit hold_armed = 1'b0;
  int errors = 0;
  int words_queued = 0;
  int unsigned cycle_cnt = 0;

  // digest model state
  logic [5:0] ds_reg;
  logic [5:0] kl_reg;
  logic [31:0] chain[8];
  logic [31:0] blk[16];
  logic [31:0] vwork[16];
  int unsigned fill;
  logic [63:0] byte_cnt;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic int unsigned digest_bytes();
    if (ds_reg == 6'd0) return 1;
    if (ds_reg > 6'd32) return 32;
    return ds_reg;
  endfunction

  task automatic restart_chain();
    int unsigned k;
    k = (kl_reg > 6'd32) ? 32 : kl_reg;
    for (int i = 0; i < 8; i++) chain[i] = b2s_pkg::IV[i];
    chain[0] ^= b2s_pkg::ParamBase | (k << 8) | digest_bytes();
    fill = 0;
    byte_cnt = '0;
  endtask

  task automatic mix(input int a, input int b, input int c, input int d,
                     input logic [31:0] x, input logic [31:0] y);
    vwork[a] = vwork[a] + vwork[b] + x;
    vwork[d] = rotr(vwork[d] ^ vwork[a], 16);
    vwork[c] = vwork[c] + vwork[d];
    vwork[b] = rotr(vwork[b] ^ vwork[c], 12);
    vwork[a] = vwork[a] + vwork[b] + y;
    vwork[d] = rotr(vwork[d] ^ vwork[a], 8);
    vwork[c] = vwork[c] + vwork[d];
    vwork[b] = rotr(vwork[b] ^ vwork[c], 7);
  endtask

  task automatic compress(input bit final_blk);
    for (int i = 0; i < 8; i++) begin
      vwork[i] = chain[i];
      vwork[i + 8] = b2s_pkg::IV[i];
    end
    vwork[12] ^= byte_cnt[31:0];
    vwork[13] ^= byte_cnt[63:32];
    if (final_blk) vwork[14] = ~vwork[14];
    for (int r = 0; r < 10; r++) begin
      mix(0, 4, 8, 12, blk[b2s_pkg::SIGMA[r][0]], blk[b2s_pkg::SIGMA[r][1]]);
      mix(1, 5, 9, 13, blk[b2s_pkg::SIGMA[r][2]], blk[b2s_pkg::SIGMA[r][3]]);
      mix(2, 6, 10, 14, blk[b2s_pkg::SIGMA[r][4]], blk[b2s_pkg::SIGMA[r][5]]);
      mix(3, 7, 11, 15, blk[b2s_pkg::SIGMA[r][6]], blk[b2s_pkg::SIGMA[r][7]]);
      mix(0, 5, 10, 15, blk[b2s_pkg::SIGMA[r][8]], blk[b2s_pkg::SIGMA[r][9]]);
      mix(1, 6, 11, 12, blk[b2s_pkg::SIGMA[r][10]], blk[b2s_pkg::SIGMA[r][11]]);
      mix(2, 7, 8, 13, blk[b2s_pkg::SIGMA[r][12]], blk[b2s_pkg::SIGMA[r][13]]);
      mix(3, 4, 9, 14, blk[b2s_pkg::SIGMA[r][14]], blk[b2s_pkg::SIGMA[r][15]]);
    end
    for (int i = 0; i < 8; i++) chain[i] ^= vwork[i] ^ vwork[i + 8];
  endtask

  // absorb one accepted item, queue digest words on the final one
  task automatic absorb(input b2s_pkg::in_item_t it);
    int unsigned n;
    int unsigned ds;
    int unsigned vb;
    b2s_pkg::out_item_t o;
    n = (it.byte_count > 3'd4) ? 4 : it.byte_count;
    for (int i = 0; i < n; i++) begin
      if (fill >= b2s_pkg::BlockBytes) begin
        byte_cnt += b2s_pkg::BlockBytes;
        compress(1'b0);
        fill = 0;
      end
      blk[fill / 4][(fill % 4) * 8 +: 8] = it.data_word[i * 8 +: 8];
      fill++;
    end
    if (it.last_word) begin
      byte_cnt += fill;
      for (int i = fill; i < b2s_pkg::BlockBytes; i++) blk[i / 4][(i % 4) * 8 +: 8] = 8'h00;
      compress(1'b1);
      ds = digest_bytes();
      for (int i = 0; i < (ds + 3) / 4; i++) begin
        vb = (ds - 4 * i > 4) ? 4 : ds - 4 * i;
        o.digest_word = (vb == 4) ? chain[i] : chain[i] & ((32'd1 << (8 * vb)) - 1);
        o.valid_bytes = 3'(vb);
        o.end_of_digest = (i + 1 == (ds + 3) / 4);
        digest_q.push_back(o);
      end
      restart_chain();
    end
  endtask

  // sender: offers queued items, holds payload until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) absorb(in_item_i);
      if (!(in_valid_i && !in_ready_o)) begin
        if (word_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid_i <= 1'b1;
          in_item_i <= word_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long hold-off of the receiver, counted in its own process
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver: random stalls, checks each digest word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h", out_item_o.digest_word);
          errors++;
        end else begin
          if (out_item_o.digest_word !== digest_q[0].digest_word) begin
            $error("digest_word exp %h got %h", digest_q[0].digest_word,
                   out_item_o.digest_word);
            errors++;
          end
          if (out_item_o.valid_bytes !== digest_q[0].valid_bytes) begin
            $error("valid_bytes exp %0d got %0d", digest_q[0].valid_bytes,
                   out_item_o.valid_bytes);
            errors++;
          end
          if (out_item_o.end_of_digest !== digest_q[0].end_of_digest) begin
            $error("end_of_digest exp %0d got %0d", digest_q[0].end_of_digest,
                   out_item_o.end_of_digest);
            errors++;
          end
          void'(digest_q.pop_front());
        end
      end
      if ((hold_armed && !hold_done) || hold_left > 0) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LimitCycles) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == b2s_pkg::REG_DIGEST_SIZE) ds_reg = val[5:0];
    else if (idx == b2s_pkg::REG_KEY_LENGTH) kl_reg = val[5:0];
    else return;
    if (fill == 0 && byte_cnt == 0) restart_chain();
  endtask

  task automatic push(input logic [31:0] d, input int cnt, input bit lst);
    b2s_pkg::in_item_t it;
    it.data_word = d;
    it.byte_count = 3'(cnt);
    it.last_word = lst;
    word_q.push_back(it);
    words_queued++;
  endtask

  function automatic logic [31:0] rand_data();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // full words with occasional short or oversized counts, then a final item
  task automatic queue_message(input int nwords);
    for (int i = 0; i < nwords; i++) begin
      case ($urandom_range(11))
        0: push(rand_data(), $urandom_range(3), 1'b0);
        1: push(rand_data(), $urandom_range(7, 5), 1'b0);
        default: push(rand_data(), 4, 1'b0);
      endcase
    end
    push(rand_data(), ($urandom_range(7) == 0) ? $urandom_range(7, 5) : $urandom_range(4),
         1'b1);
  endtask

  // keyed message: key block of zero-padded key bytes sent as data
  task automatic queue_keyed(input int klen, input int nwords);
    logic [31:0] kw;
    for (int i = 0; i < 16; i++) begin
      kw = $urandom();
      for (int b = 0; b < 4; b++) if (i * 4 + b >= klen) kw[b * 8 +: 8] = 8'h00;
      push(kw, 4, 1'b0);
    end
    queue_message(nwords);
  endtask

  // wait until nothing is left to send or check, then let the block settle
  task automatic drain();
    while (word_q.size() > 0 || in_valid_i || digest_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    ds_reg = 6'd32;
    kl_reg = 6'd0;
    restart_chain();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, empty message, block boundaries, odd counts, then size and key limits, keyed
    push(32'h0, 0, 1'b1);
    push(32'hFFFF_FFFF, 4, 1'b1);
    for (int i = 0; i < 16; i++) push(32'hFFFF_FFFF, 4, 1'b0);
    push(32'h0, 0, 1'b1);
    push(32'h1234_5678, 0, 1'b0);
    push(32'hA5A5_A5A5, 2, 1'b0);
    push(32'h5A5A_5A5A, 7, 1'b0);
    push(32'hDEAD_BEEF, 3, 1'b1);
    drain();
    write_reg(b2s_pkg::REG_DIGEST_SIZE, 32'd0);
    write_reg(b2s_pkg::REG_KEY_LENGTH, 32'd63);
    write_reg(RegUnmapped, 32'hFFFF_FFFF);
    queue_message(1);
    drain();
    write_reg(b2s_pkg::REG_DIGEST_SIZE, 32'hFFFF_FFFF);
    write_reg(b2s_pkg::REG_KEY_LENGTH, 32'd32);
    queue_keyed(32, 0);
    drain();

    // random messages across settings and idling modes
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 31 : (ph == 1) ? 69 : 0;
      recv_idle = (ph == 0) ? 69 : (ph == 1) ? 31 : 0;
      if (ph == 1) hold_armed = 1'b1;
      for (int m = 0; m < 2; m++) begin
        write_reg(b2s_pkg::REG_DIGEST_SIZE, (m == 0) ? 32'd1 : $urandom_range(63));
        write_reg(b2s_pkg::REG_KEY_LENGTH, (m == 0) ? 32'd0 : $urandom_range(63));
        for (int j = 0; j < 3; j++) begin
          if ($urandom_range(3) == 0) queue_keyed($urandom_range(1, 32), $urandom_range(12));
          else queue_message(($urandom_range(9) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(10));
        end
        drain();
        if (words_queued >= 320 && ph == 2) break;
      end
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
